/* rtl/waiter_timer_queue_unit_defines.svh */
// Assertion macros shared by the waiter timer queue checker.
`ifndef WAITER_TIMER_QUEUE_UNIT_DEFINES_SVH
`define WAITER_TIMER_QUEUE_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define WTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define WTQ_NEVER(lbl, expr, msg) \
  `WTQ_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/wtq_pkg.sv */
// Types, codes and sizes shared by the waiter timer queue modules.
`timescale 1ns / 1ps
package wtq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int TIME_W      = 48;
  localparam int ID_W        = 32;
  localparam int CNT_W       = 32;
  localparam int IN_DATA_W   = TIME_W + 3 * CNT_W;

  typedef logic [IDX_W-1:0] idx_t;

  // input actions
  localparam logic [2:0] A_ARM_DL = 3'd0;
  localparam logic [2:0] A_ARM_NT = 3'd1;
  localparam logic [2:0] A_ARM_CW = 3'd2;
  localparam logic [2:0] A_CANCEL = 3'd3;
  localparam logic [2:0] A_TICK   = 3'd4;

  // result kinds
  localparam logic [2:0] K_ARMED     = 3'd0;
  localparam logic [2:0] K_FULL      = 3'd1;
  localparam logic [2:0] K_FIRED     = 3'd2;
  localparam logic [2:0] K_CANCELLED = 3'd3;
  localparam logic [2:0] K_NOTFOUND  = 3'd4;
  localparam logic [2:0] K_TICKDONE  = 3'd5;

  // table selects
  localparam logic [1:0] TBL_DL = 2'd0;
  localparam logic [1:0] TBL_NT = 2'd1;
  localparam logic [1:0] TBL_CW = 2'd2;

  typedef struct packed {
    logic       load;
    logic       arm;
    logic       tick_inc;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_last;
    logic       idx_clr;
    logic       idx_inc;
    logic       sel_load;
    logic [1:0] sel_val;
    logic       scan_tick;
    logic       best_clr;
    logic       cancel_clr;
    logic       fire_clr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       full;
    logic       match;
    logic       idx_end;
    logic       best_vld;
    logic [1:0] tbl_sel;
    logic       out_vld;
  } sts_t;

endpackage

/* rtl/wtq_ctrl.sv */
// Sequencer for arm, cancel scan and tick fire passes.
`timescale 1ns / 1ps
module wtq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wtq_pkg::sts_t sts_i,
  output wtq_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CSCAN  = 3'd2;
  localparam logic [2:0] S_TSCAN  = 3'd3;
  localparam logic [2:0] S_TDEC   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       last_q, last_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.action)
          wtq_pkg::A_ARM_DL, wtq_pkg::A_ARM_NT, wtq_pkg::A_ARM_CW: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            last_d          = 1'b1;
            state_d         = S_EMIT;
            if (sts_i.full) begin
              cmd_o.emit_kind = wtq_pkg::K_FULL;
            end else begin
              cmd_o.arm       = 1'b1;
              cmd_o.emit_kind = wtq_pkg::K_ARMED;
            end
          end
          wtq_pkg::A_CANCEL: begin
            cmd_o.sel_load = 1'b1;
            cmd_o.sel_val  = wtq_pkg::TBL_DL;
            cmd_o.idx_clr  = 1'b1;
            state_d        = S_CSCAN;
          end
          wtq_pkg::A_TICK: begin
            cmd_o.tick_inc = 1'b1;
            cmd_o.sel_load = 1'b1;
            cmd_o.sel_val  = wtq_pkg::TBL_NT;
            cmd_o.idx_clr  = 1'b1;
            cmd_o.best_clr = 1'b1;
            state_d        = S_TSCAN;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CSCAN: begin
        if (sts_i.match) begin
          cmd_o.cancel_clr = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.emit_kind  = wtq_pkg::K_CANCELLED;
          cmd_o.emit_last  = 1'b1;
          last_d           = 1'b1;
          state_d          = S_EMIT;
        end else if (sts_i.idx_end) begin
          if (sts_i.tbl_sel == wtq_pkg::TBL_CW) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = wtq_pkg::K_NOTFOUND;
            cmd_o.emit_last = 1'b1;
            last_d          = 1'b1;
            state_d         = S_EMIT;
          end else begin
            cmd_o.sel_load = 1'b1;
            cmd_o.sel_val  = (sts_i.tbl_sel == wtq_pkg::TBL_DL) ? wtq_pkg::TBL_NT
                                                                : wtq_pkg::TBL_CW;
            cmd_o.idx_clr  = 1'b1;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_TSCAN: begin
        cmd_o.scan_tick = 1'b1;
        if (sts_i.idx_end) begin
          state_d = S_TDEC;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_TDEC: begin
        cmd_o.idx_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
        if (sts_i.best_vld) begin
          // fire the earliest due waiter, then rescan the same table
          cmd_o.fire_clr  = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = wtq_pkg::K_FIRED;
          last_d          = 1'b0;
          state_d         = S_EMIT;
        end else if (sts_i.tbl_sel == wtq_pkg::TBL_CW) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = wtq_pkg::K_TICKDONE;
          cmd_o.emit_last = 1'b1;
          last_d          = 1'b1;
          state_d         = S_EMIT;
        end else begin
          // tick order: next tick, then deadline, then count
          cmd_o.sel_load = 1'b1;
          cmd_o.sel_val  = (sts_i.tbl_sel == wtq_pkg::TBL_NT) ? wtq_pkg::TBL_DL
                                                              : wtq_pkg::TBL_CW;
          state_d        = S_TSCAN;
        end
      end
      S_EMIT: begin
        if (!sts_i.out_vld) begin
          state_d = last_q ? S_IDLE : S_TSCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/wtq_datapath.sv */
// Waiter tables, counters, scan compare and result register.
`timescale 1ns / 1ps
module wtq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wtq_pkg::cmd_t                     cmd_i,
  output wtq_pkg::sts_t                     sts_o,
  input  logic [2:0]                        in_action_i,
  input  logic [wtq_pkg::IN_DATA_W-1:0]     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        out_kind_o,
  output logic [wtq_pkg::ID_W-1:0]          out_id_o,
  output logic                              out_last_o
);

  localparam int TW = wtq_pkg::TIME_W;
  localparam int CW = wtq_pkg::CNT_W;
  localparam int IW = wtq_pkg::ID_W;
  localparam int D  = wtq_pkg::TABLE_DEPTH;

  // latched item
  logic [2:0]    action_q;
  logic [TW-1:0] now_q;
  logic [CW-1:0] delay_q, count_q;
  logic [IW-1:0] target_q;

  // tables
  logic [TW-1:0] dl_key_q [D];
  logic [IW-1:0] dl_own_q [D];
  logic [IW-1:0] nt_own_q [D];
  logic [CW-1:0] cw_key_q [D];
  logic [IW-1:0] cw_own_q [D];
  logic [D-1:0]  dl_vld_q, nt_vld_q, cw_vld_q;

  logic [CW-1:0] ticks_q;
  logic [IW-1:0] idgen_q;

  // scan state
  wtq_pkg::idx_t idx_q;
  logic [1:0]    sel_q;
  logic          best_vld_q;
  logic [TW-1:0] best_key_q;
  logic [IW-1:0] best_own_q;
  wtq_pkg::idx_t best_slot_q;

  // result register
  logic          out_vld_q;
  logic [2:0]    out_kind_q;
  logic [IW-1:0] out_id_q;
  logic          out_last_q;

  // arm path
  logic [D-1:0]  arm_vld;
  wtq_pkg::idx_t free_slot;
  logic          full;
  logic [IW-1:0] new_id;
  logic [TW:0]   dl_sum;
  logic [TW-1:0] dl_new;
  logic [CW:0]   cw_sum;
  logic [CW-1:0] cw_new;

  // scan entry
  logic          ent_vld;
  logic [TW-1:0] ent_key, ent_lim;
  logic [IW-1:0] ent_own;
  logic          due, better;

  always_comb begin
    case (action_q)
      wtq_pkg::A_ARM_DL: arm_vld = dl_vld_q;
      wtq_pkg::A_ARM_NT: arm_vld = nt_vld_q;
      default:           arm_vld = cw_vld_q;
    endcase
  end

  always_comb begin
    free_slot = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!arm_vld[i]) free_slot = wtq_pkg::idx_t'(i);
    end
  end

  assign full   = &arm_vld;
  assign new_id = idgen_q + IW'(1);
  assign dl_sum = {1'b0, now_q} + (TW + 1)'(delay_q);
  assign dl_new = dl_sum[TW] ? {TW{1'b1}} : dl_sum[TW-1:0];
  assign cw_sum = {1'b0, ticks_q} + (CW + 1)'(count_q);
  assign cw_new = cw_sum[CW] ? {CW{1'b1}} : cw_sum[CW-1:0];

  always_comb begin
    case (sel_q)
      wtq_pkg::TBL_DL: begin
        ent_vld = dl_vld_q[idx_q];
        ent_key = dl_key_q[idx_q];
        ent_own = dl_own_q[idx_q];
        ent_lim = now_q;
      end
      wtq_pkg::TBL_NT: begin
        ent_vld = nt_vld_q[idx_q];
        ent_key = '0;
        ent_own = nt_own_q[idx_q];
        ent_lim = '0;
      end
      wtq_pkg::TBL_CW: begin
        ent_vld = cw_vld_q[idx_q];
        ent_key = TW'(cw_key_q[idx_q]);
        ent_own = cw_own_q[idx_q];
        ent_lim = TW'(ticks_q);
      end
      default: begin
        ent_vld = 1'b0;
        ent_key = '0;
        ent_own = '0;
        ent_lim = '0;
      end
    endcase
  end

  assign due    = ent_vld && (ent_key <= ent_lim);
  // strict compare keeps the lowest slot on a full tie
  assign better = !best_vld_q || (ent_key < best_key_q) ||
                  ((ent_key == best_key_q) && (ent_own < best_own_q));

  assign sts_o.action   = action_q;
  assign sts_o.full     = full;
  assign sts_o.match    = ent_vld && (ent_own == target_q);
  assign sts_o.idx_end  = (idx_q == wtq_pkg::idx_t'(D - 1));
  assign sts_o.best_vld = best_vld_q;
  assign sts_o.tbl_sel  = sel_q;
  assign sts_o.out_vld  = out_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= in_action_i;
      now_q    <= in_data_i[TW-1:0];
      delay_q  <= in_data_i[TW+CW-1:TW];
      count_q  <= in_data_i[TW+2*CW-1:TW+CW];
      target_q <= in_data_i[TW+3*CW-1:TW+2*CW];
    end
    if (cmd_i.arm) begin
      case (action_q)
        wtq_pkg::A_ARM_DL: begin
          dl_key_q[free_slot] <= dl_new;
          dl_own_q[free_slot] <= new_id;
        end
        wtq_pkg::A_ARM_NT: nt_own_q[free_slot] <= new_id;
        default: begin
          cw_key_q[free_slot] <= cw_new;
          cw_own_q[free_slot] <= new_id;
        end
      endcase
    end
    if (cmd_i.scan_tick && due && better) begin
      best_key_q  <= ent_key;
      best_own_q  <= ent_own;
      best_slot_q <= idx_q;
    end
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_last_q <= cmd_i.emit_last;
      case (cmd_i.emit_kind)
        wtq_pkg::K_ARMED:                        out_id_q <= new_id;
        wtq_pkg::K_FIRED:                        out_id_q <= best_own_q;
        wtq_pkg::K_CANCELLED, wtq_pkg::K_NOTFOUND: out_id_q <= target_q;
        default:                                 out_id_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q   <= '0;
      nt_vld_q   <= '0;
      cw_vld_q   <= '0;
      ticks_q    <= '0;
      idgen_q    <= '0;
      idx_q      <= '0;
      sel_q      <= wtq_pkg::TBL_DL;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.arm) begin
        idgen_q <= new_id;
        case (action_q)
          wtq_pkg::A_ARM_DL: dl_vld_q[free_slot] <= 1'b1;
          wtq_pkg::A_ARM_NT: nt_vld_q[free_slot] <= 1'b1;
          default:           cw_vld_q[free_slot] <= 1'b1;
        endcase
      end
      if (cmd_i.cancel_clr || cmd_i.fire_clr) begin
        case (sel_q)
          wtq_pkg::TBL_DL: dl_vld_q[cmd_i.fire_clr ? best_slot_q : idx_q] <= 1'b0;
          wtq_pkg::TBL_NT: nt_vld_q[cmd_i.fire_clr ? best_slot_q : idx_q] <= 1'b0;
          default:         cw_vld_q[cmd_i.fire_clr ? best_slot_q : idx_q] <= 1'b0;
        endcase
      end
      if (cmd_i.tick_inc) ticks_q <= ticks_q + CW'(1);
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + wtq_pkg::idx_t'(1);
      end
      if (cmd_i.sel_load) sel_q <= cmd_i.sel_val;
      if (cmd_i.best_clr) begin
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan_tick && due) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/waiter_timer_queue_unit.sv */
// Arm: the item is latched in idle and its result is registered from the decode state. A cancel
// result follows a scan of up to three tables, one table entry scanned per cycle.
// Tick: each table pass scans every entry of one table and fires at most one waiter; tick done is
// the last result, after the passes over the next tick, deadline and count tables.
// One item in work at a time; the next is taken once the last result has been accepted.
// Reset (async, active low) clears all valid bits, the tick counter and the id counter.
`timescale 1ns / 1ps
module waiter_timer_queue_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_time[47:0], delay[79:48], tick_count[111:80], target_id[143:112]
  input  logic [wtq_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // action[2:0]
  input  logic [2:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // waiter_id[31:0]
  output logic [wtq_pkg::ID_W-1:0]      m_axis_tdata_o,
  // kind[2:0]
  output logic [2:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  wtq_pkg::cmd_t cmd;
  wtq_pkg::sts_t sts;

  wtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wtq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_action_i (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_id_o    (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

/* rtl/wtq_checker.sv */
// Port-level checks for the waiter timer queue, bound to the top level.
`timescale 1ns / 1ps
`include "waiter_timer_queue_unit_defines.svh"
module wtq_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready_i,
  input logic                     m_axis_tvalid_i,
  input logic                     m_axis_tready_i,
  input logic [wtq_pkg::ID_W-1:0] m_axis_tdata_i,
  input logic [2:0]               m_axis_tuser_i,
  input logic                     m_axis_tlast_i
);

  `WTQ_ASSERT(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i), "result changed while stalled")
  `WTQ_NEVER(a_no_take_busy, s_axis_tready_i && m_axis_tvalid_i, "item taken with result pending")
  `WTQ_ASSERT(a_done_zero, m_axis_tvalid_i && m_axis_tuser_i == wtq_pkg::K_TICKDONE |-> m_axis_tdata_i == '0 && m_axis_tlast_i, "tick done malformed")
  `WTQ_ASSERT(a_single_last, m_axis_tvalid_i && (m_axis_tuser_i == wtq_pkg::K_ARMED || m_axis_tuser_i == wtq_pkg::K_FULL || m_axis_tuser_i == wtq_pkg::K_CANCELLED || m_axis_tuser_i == wtq_pkg::K_NOTFOUND) |-> m_axis_tlast_i, "single result not last")
  `WTQ_NEVER(a_fired_last, m_axis_tvalid_i && m_axis_tuser_i == wtq_pkg::K_FIRED && m_axis_tlast_i, "fired result marked last")

endmodule

bind waiter_timer_queue_unit wtq_checker u_wtq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

/* test/tb_waiter_timer_queue_unit.sv */
// Self-checking testbench for the waiter timer queue: random and directed items, scoreboard.
`timescale 1ns / 1ps
module tb_waiter_timer_queue_unit;
  import wtq_pkg::*;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] wid;
    logic            last;
  } res_t;

  // Mirror of the queue state; predicts the results of each accepted item.
  class waiter_scoreboard;
    logic [TIME_W-1:0] dl_key[TABLE_DEPTH];
    logic [ID_W-1:0]   dl_own[TABLE_DEPTH];
    bit                dl_vld[TABLE_DEPTH];
    logic [ID_W-1:0]   nt_own[TABLE_DEPTH];
    bit                nt_vld[TABLE_DEPTH];
    logic [CNT_W-1:0]  cw_key[TABLE_DEPTH];
    logic [ID_W-1:0]   cw_own[TABLE_DEPTH];
    bit                cw_vld[TABLE_DEPTH];
    logic [CNT_W-1:0]  ticks;
    logic [ID_W-1:0]   last_id;
    res_t              pending[$];
    int                errors;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        dl_vld[i] = 0; nt_vld[i] = 0; cw_vld[i] = 0;
      end
      ticks = 0; last_id = 0; errors = 0;
    endfunction

    function void push(logic [2:0] k, logic [ID_W-1:0] id);
      res_t r;
      r.kind = k; r.wid = id; r.last = 0;
      pending = {pending, r};
    endfunction

    // table 0 deadline, 1 next tick, 2 count; key widened to 48 bits
    function int pick_due(int tbl, logic [TIME_W-1:0] lim);
      int best;
      logic [TIME_W-1:0] k, bk;
      logic [ID_W-1:0] o, bo;
      bit v;
      best = -1; bk = 0; bo = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        case (tbl)
          0: begin v = dl_vld[i]; k = dl_key[i]; o = dl_own[i]; end
          1: begin v = nt_vld[i]; k = 0; o = nt_own[i]; end
          default: begin v = cw_vld[i]; k = TIME_W'(cw_key[i]); o = cw_own[i]; end
        endcase
        if (v && k <= lim && (best < 0 || k < bk || (k == bk && o < bo))) begin
          best = i; bk = k; bo = o;
        end
      end
      return best;
    endfunction

    function void note_item(logic [2:0] act, logic [IN_DATA_W-1:0] d);
      logic [TIME_W-1:0] now;
      logic [TIME_W:0]   dsum;
      logic [CNT_W:0]    csum;
      logic [CNT_W-1:0]  dly, cnt, tgt;
      int slot, n_prior;
      bit done;
      now = d[47:0]; dly = d[79:48]; cnt = d[111:80]; tgt = d[143:112];
      n_prior = pending.size();
      slot = -1;
      if (act == A_ARM_DL || act == A_ARM_NT || act == A_ARM_CW) begin
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
          if (!(act == A_ARM_DL ? dl_vld[i] : act == A_ARM_NT ? nt_vld[i] : cw_vld[i]))
            slot = i;
        if (slot < 0) push(K_FULL, '0);
        else begin
          last_id = last_id + 1;
          if (act == A_ARM_DL) begin
            dsum = {1'b0, now} + dly;
            dl_key[slot] = dsum[TIME_W] ? '1 : dsum[TIME_W-1:0];
            dl_own[slot] = last_id; dl_vld[slot] = 1;
          end else if (act == A_ARM_NT) begin
            nt_own[slot] = last_id; nt_vld[slot] = 1;
          end else begin
            csum = {1'b0, ticks} + cnt;
            cw_key[slot] = csum[CNT_W] ? '1 : csum[CNT_W-1:0];
            cw_own[slot] = last_id; cw_vld[slot] = 1;
          end
          push(K_ARMED, last_id);
        end
      end else if (act == A_CANCEL) begin
        done = 0;
        for (int i = 0; i < TABLE_DEPTH && !done; i++)
          if (dl_vld[i] && dl_own[i] == tgt) begin dl_vld[i] = 0; done = 1; end
        for (int i = 0; i < TABLE_DEPTH && !done; i++)
          if (nt_vld[i] && nt_own[i] == tgt) begin nt_vld[i] = 0; done = 1; end
        for (int i = 0; i < TABLE_DEPTH && !done; i++)
          if (cw_vld[i] && cw_own[i] == tgt) begin cw_vld[i] = 0; done = 1; end
        push(done ? K_CANCELLED : K_NOTFOUND, tgt);
      end else if (act == A_TICK) begin
        ticks = ticks + 1;
        while ((slot = pick_due(1, '0)) >= 0) begin
          push(K_FIRED, nt_own[slot]); nt_vld[slot] = 0;
        end
        while ((slot = pick_due(0, now)) >= 0) begin
          push(K_FIRED, dl_own[slot]); dl_vld[slot] = 0;
        end
        while ((slot = pick_due(2, TIME_W'(ticks))) >= 0) begin
          push(K_FIRED, cw_own[slot]); cw_vld[slot] = 0;
        end
        push(K_TICKDONE, '0);
      end
      if (pending.size() > n_prior) pending[pending.size() - 1].last = 1;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %0d", got.kind, got.wid));
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.wid !== want.wid)
        report_mismatch($sformatf("waiter_id %0d, want %0d", got.wid, want.wid));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  localparam int WATCHDOG = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic [2:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [ID_W-1:0] m_axis_tdata_o;
  logic [2:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  waiter_scoreboard sb;
  bit calm = 0;
  int idle_cnt = 0;

  waiter_timer_queue_unit DUT (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // valid stays up after an accept so a following item can go back to back
  task automatic send_item(logic [2:0] act, logic [TIME_W-1:0] now, logic [CNT_W-1:0] dly,
                           logic [CNT_W-1:0] cnt, logic [ID_W-1:0] tgt);
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {tgt, cnt, dly, now};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // accepted input and output items go to the scoreboard; sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_item(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result('{m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o});
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      m_axis_tready_i <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= WATCHDOG) begin
      $display("** waiter_timer_queue_unit: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    s_axis_tvalid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3 * TABLE_DEPTH + 8) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] pick_target();
    case ($urandom_range(3))
      0: return $urandom();
      1: return '1;
      default: return sb.last_id - $urandom_range(12);
    endcase
  endfunction

  initial begin
    logic [2:0] act;
    logic [TIME_W-1:0] now;
    int r;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, every action, full tables, not found, saturation, undefined actions
    send_item(A_TICK, '0, '0, '0, '0);
    send_item(A_CANCEL, '0, '0, '0, '1);
    send_item(A_ARM_DL, '1, '1, '1, '1);
    send_item(A_ARM_CW, '0, '0, '1, '0);
    send_item(A_ARM_DL, 48'd10, 32'd0, '0, '0);
    send_item(A_ARM_DL, 48'd5, 32'd5, '0, '0);
    send_item(A_ARM_CW, '0, '0, 32'd0, '0);
    send_item(A_ARM_NT, '0, '0, '0, '0);
    send_item(3'd5, '1, '1, '1, '1);
    send_item(3'd7, '0, '0, '0, '0);
    send_item(3'd6, '0, '0, '0, '0);
    send_item(A_CANCEL, '0, '0, '0, 32'd1);
    send_item(A_TICK, 48'd10, '0, '0, '0);
    for (int i = 0; i < TABLE_DEPTH + 1; i++) send_item(A_ARM_NT, '0, '0, '0, '0);
    wait_drained();
    send_item(A_TICK, '1, '1, '1, '1);

    // random part: mostly arms and ticks with modest times, some cancels and noise
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 220);
      if (n == 300) wait_drained();
      r = $urandom_range(99);
      act = r < 25 ? A_ARM_DL : r < 40 ? A_ARM_NT : r < 60 ? A_ARM_CW :
            r < 75 ? A_CANCEL : r < 96 ? A_TICK : 3'($urandom_range(7, 5));
      now = ($urandom_range(15) == 0) ? 48'({$urandom(), $urandom()}) :
                                        48'($urandom_range(300));
      send_item(act, now,
                ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(200)),
                ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(8)),
                pick_target());
    end

    wait_drained();
    if (sb.errors == 0)
      $display("** waiter_timer_queue_unit: PASSED **");
    else
      $display("** waiter_timer_queue_unit: FAILED **");
    $finish;
  end
endmodule
